// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the melody tone sequencer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Types, constants and the melody note table of the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Table geometry
  localparam int NUM_MELODIES     = 13;
  localparam int NOTES_PER_MELODY = 6;
  localparam int NOTE_IDX_W       = (NOTES_PER_MELODY > 1) ? $clog2(NOTES_PER_MELODY) : 1;

  // Field widths
  localparam int MEL_W  = 4;
  localparam int STEP_W = 4;
  localparam int TICK_W = 16;
  localparam int DIV_W  = 16;

  // Last step (off time of the last note) and the step after it
  localparam logic [STEP_W-1:0] LAST_STEP     = STEP_W'(2 * NOTES_PER_MELODY);
  localparam logic [STEP_W-1:0] LAST_STEP_END = STEP_W'(2 * NOTES_PER_MELODY + 1);

  localparam logic [MEL_W-1:0]  MELODY_POWER_ON = MEL_W'(1);

  // Base tone divisors (octave 4)
  localparam int BASE_D4  = 54483;
  localparam int BASE_E4  = 48539;
  localparam int BASE_FS4 = 43243;
  localparam int BASE_G4  = 40816;
  localparam int BASE_A4  = 36363;
  localparam int BASE_B4  = 32395;

  localparam logic [DIV_W-1:0] TN_B5  = DIV_W'(BASE_B4 / 2);
  localparam logic [DIV_W-1:0] TN_D6  = DIV_W'(BASE_D4 / 4);
  localparam logic [DIV_W-1:0] TN_E6  = DIV_W'(BASE_E4 / 4);
  localparam logic [DIV_W-1:0] TN_FS6 = DIV_W'(BASE_FS4 / 4);
  localparam logic [DIV_W-1:0] TN_G6  = DIV_W'(BASE_G4 / 4);
  localparam logic [DIV_W-1:0] TN_A6  = DIV_W'(BASE_A4 / 4);
  localparam logic [DIV_W-1:0] TN_D7  = DIV_W'(BASE_D4 / 8);

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CONTROL = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef struct packed {
    logic [DIV_W-1:0]  div;
    logic [TICK_W-1:0] on_ticks;
    logic [TICK_W-1:0] off_ticks;
  } note_t;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_TICK,
    OP_STOP,
    OP_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
  } dp_cmd_t;

  typedef struct packed {
    logic muted;      // sound off and power-on melody already played
    logic mel_known;  // current melody has a table row
    logic idle;       // no step armed and no time left
    logic step_live;  // a sequence step is due now
    logic note_zero;  // due step loads a zero divisor
    logic seq_end;    // sequence ran past the last note
  } dp_status_t;

  localparam note_t NOTE_REST = '{div: '0, on_ticks: '0, off_ticks: '0};

  function automatic note_t mk_note(logic [DIV_W-1:0] d, int on_t, int off_t);
    note_t n;
    n.div       = d;
    n.on_ticks  = TICK_W'(on_t);
    n.off_ticks = TICK_W'(off_t);
    return n;
  endfunction

  // Melody table: one row per melody, one entry per note
  localparam note_t MELODY_ROM [NUM_MELODIES][NOTES_PER_MELODY] = '{
    '{NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST},
    '{mk_note(TN_B5, 4, 19), mk_note(TN_D6, 4, 19), mk_note(TN_G6, 4, 19),
      mk_note(TN_FS6, 5, 65), mk_note(TN_D7, 10, 112), NOTE_REST},
    '{mk_note(TN_A6, 4, 19), mk_note(TN_G6, 4, 19), mk_note(TN_E6, 4, 19),
      mk_note(TN_FS6, 5, 65), mk_note(TN_D6, 10, 110), NOTE_REST},
    '{mk_note(TN_A6, 8, 28), NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST},
    '{mk_note(TN_G6, 5, 19), mk_note(TN_D7, 10, 38), NOTE_REST, NOTE_REST, NOTE_REST,
      NOTE_REST},
    '{mk_note(TN_D7, 5, 19), mk_note(TN_G6, 10, 38), mk_note(TN_D6, 0, 0), NOTE_REST,
      NOTE_REST, NOTE_REST},
    '{mk_note(TN_D6, 2, 10), mk_note(TN_D7, 8, 28), mk_note(TN_D6, 2, 10),
      mk_note(TN_D7, 8, 28), NOTE_REST, NOTE_REST},
    '{mk_note(TN_B5, 6, 18), mk_note(TN_FS6, 6, 18), mk_note(TN_E6, 6, 42), NOTE_REST,
      NOTE_REST, NOTE_REST},
    '{mk_note(TN_A6, 7, 29), NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST, NOTE_REST},
    '{mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29), NOTE_REST, NOTE_REST, NOTE_REST,
      NOTE_REST},
    '{mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29), NOTE_REST,
      NOTE_REST, NOTE_REST},
    '{mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29),
      mk_note(TN_A6, 7, 29), NOTE_REST, NOTE_REST},
    '{mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29),
      mk_note(TN_A6, 7, 29), mk_note(TN_A6, 7, 29), NOTE_REST}
  };

endpackage

// File: sv/melody_tone_sequencer_core.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer_core
// Melody tone sequencer: plays fixed melodies from a note table, one result
// beat per input beat.
// ----------------------------------------------------------------------------
// A start, tick or unused beat is accepted and then loads the result
// register. A control beat is accepted and evaluated, walks the sequence
// steps, closes the walk and then loads the result register. A control beat
// that mutes, stops an idle sequencer or names an unknown melody skips the
// step walk. The controller advances the step sequence one step per clock
// through the single note table lookup. The load cycle waits while an
// earlier result is still held and not taken. The next input beat is
// accepted once the previous result sits in the output register, even if
// that result has not yet been taken. Each result shows the buzzer drive,
// the loaded tone divisor, the tone timer state and whether a melody is in
// progress after the beat. The sound enable register is written through the
// cfg port, which is always ready; write it only while idle.
module melody_tone_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_sound_enable,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_melody,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tone_on,
  output logic [15:0] out_note_divisor,
  output logic        out_tone_timer_run,
  output logic        out_busy_res
);
  import mts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mts_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_sound_enable   (cfg_sound_enable),
    .in_melody          (in_melody),
    .cmd                (cmd),
    .status             (status),
    .out_tone_on        (out_tone_on),
    .out_note_divisor   (out_note_divisor),
    .out_tone_timer_run (out_tone_timer_run),
    .out_busy_res       (out_busy_res)
  );

endmodule

// File: sv/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer controller: accepts beats, walks the note steps one per cycle
// and hands the finished state to the output register.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  output logic                out_valid,
  input  logic                out_ready,
  input  mts_pkg::dp_status_t status,
  output mts_pkg::dp_cmd_t    cmd
);
  import mts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOOP,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath command
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.capture = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (action_t'(in_action))
            ACT_START: begin
              cmd.op    = OP_START;
              state_nxt = ST_FINISH;
            end
            ACT_TICK: begin
              cmd.op    = OP_TICK;
              state_nxt = ST_FINISH;
            end
            ACT_CONTROL: state_nxt = ST_EVAL;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_EVAL: begin
        if (status.muted) begin
          cmd.op    = OP_STOP;
          state_nxt = ST_FINISH;
        end else if (!status.mel_known) begin
          state_nxt = ST_FINISH;
        end else if (status.idle) begin
          cmd.op    = OP_STOP;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        // One sequence step per cycle until time is loaded or the melody ends
        if (status.step_live) begin
          if (status.note_zero) begin
            cmd.op    = OP_STOP;
            state_nxt = ST_FINISH;
          end else begin
            cmd.op = OP_STEP;
          end
        end else if (status.seq_end) begin
          cmd.op    = OP_STOP;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Load the result beat, drop it once taken
  always_comb begin
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath
// Sequencer state, note table lookup, sound enable register and the
// result register.
// ----------------------------------------------------------------------------
module mts_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_sound_enable,
  input  logic [3:0]          in_melody,
  input  mts_pkg::dp_cmd_t    cmd,
  output mts_pkg::dp_status_t status,
  output logic                out_tone_on,
  output logic [15:0]         out_note_divisor,
  output logic                out_tone_timer_run,
  output logic                out_busy_res
);
  import mts_pkg::*;

  logic                  sound_en_r;
  logic [MEL_W-1:0]      mel_r, mel_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [TICK_W-1:0]     ticks_r, ticks_nxt;
  logic                  po_played_r, po_played_nxt;
  logic                  tone_r, tone_nxt;
  logic                  timer_r, timer_nxt;
  logic [DIV_W-1:0]      div_r, div_nxt;

  logic [STEP_W-1:0]     step_m1;
  logic [NOTE_IDX_W-1:0] note_idx;
  note_t                 note;
  logic                  no_time;

  // Note under the current step: steps 2k+1 and 2k+2 belong to note k
  assign step_m1  = step_r - STEP_W'(1);
  assign note_idx = step_m1[NOTE_IDX_W:1];
  assign note     = MELODY_ROM[mel_r][note_idx];
  assign no_time  = (ticks_r == '0);

  assign status.muted     = !sound_en_r && po_played_r;
  assign status.mel_known = ({1'b0, mel_r} < (MEL_W + 1)'(NUM_MELODIES));
  assign status.idle      = (step_r == '0) && no_time;
  assign status.step_live = (step_r != '0) && (step_r <= LAST_STEP) && no_time;
  assign status.note_zero = step_r[0] && (note.div == '0);
  assign status.seq_end   = (step_r == LAST_STEP_END) && no_time;

  // Apply the controller's operation
  always_comb begin
    mel_nxt       = mel_r;
    step_nxt      = step_r;
    ticks_nxt     = ticks_r;
    po_played_nxt = po_played_r;
    tone_nxt      = tone_r;
    timer_nxt     = timer_r;
    div_nxt       = div_r;
    case (cmd.op)
      OP_START: begin
        ticks_nxt = '0;
        step_nxt  = STEP_W'(1);
        mel_nxt   = in_melody;
      end
      OP_TICK: begin
        if (!no_time) begin
          ticks_nxt = ticks_r - TICK_W'(1);
        end
      end
      OP_STOP: begin
        if (mel_r == MELODY_POWER_ON) begin
          po_played_nxt = 1'b1;
        end
        timer_nxt = 1'b0;
        div_nxt   = '0;
        tone_nxt  = 1'b0;
        ticks_nxt = '0;
        step_nxt  = '0;
        mel_nxt   = '0;
      end
      OP_STEP: begin
        // Odd step sounds the note, even step holds the rest after it
        if (step_r[0]) begin
          timer_nxt = 1'b1;
          div_nxt   = note.div;
          tone_nxt  = 1'b1;
          ticks_nxt = note.on_ticks;
        end else begin
          tone_nxt  = 1'b0;
          ticks_nxt = note.off_ticks;
        end
        step_nxt = step_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_en_r  <= 1'b1;
      mel_r       <= '0;
      step_r      <= '0;
      ticks_r     <= '0;
      po_played_r <= 1'b0;
      tone_r      <= 1'b0;
      timer_r     <= 1'b0;
      div_r       <= '0;
    end else begin
      if (cfg_we) begin
        sound_en_r <= cfg_sound_enable;
      end
      mel_r       <= mel_nxt;
      step_r      <= step_nxt;
      ticks_r     <= ticks_nxt;
      po_played_r <= po_played_nxt;
      tone_r      <= tone_nxt;
      timer_r     <= timer_nxt;
      div_r       <= div_nxt;
    end
  end

  // Result register: snapshot of the state after the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_tone_on        <= tone_r;
      out_note_divisor   <= div_r;
      out_tone_timer_run <= timer_r;
      out_busy_res       <= (step_r != '0);
    end
  end

endmodule

// File: sv/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the melody tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_tone_on,
  input logic [15:0] out_note_divisor,
  input logic        out_tone_timer_run,
  input logic        out_busy_res
);

  // Hold a stalled result beat
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_note_divisor) && $stable(out_tone_on) && $stable(out_busy_res), "result beat changed while stalled")

  // One item at a time: no acceptance right after an acceptance
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while busy")

  // Stopped sequencer reports silence
  `ASSERT_NOW(a_idle_quiet, clk, rst_n, out_valid && !out_busy_res, out_note_divisor == 16'd0 && !out_tone_on && !out_tone_timer_run, "idle result not silent")

  // Buzzer drive only with a running timer and a loaded divisor
  `ASSERT_NOW(a_tone_timer, clk, rst_n, out_valid && out_tone_on, out_tone_timer_run && out_note_divisor != 16'd0, "tone on without running timer")

endmodule

bind melody_tone_sequencer_core mts_checker u_mts_checker (.*);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the melody tone sequencer core. A queue of input
// beats (directed, then random melody playback with ticks and control beats)
// feeds a valid/ready driver. Each accepted beat runs through a local model of
// the sequencer, and the monitor checks every result beat against it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int SONG_COUNT = 13;
  localparam int NOTE_SLOTS = 6;
  localparam logic [3:0] FINAL_STEP = 4'd12;
  localparam logic [3:0] POWER_ON_SONG = 4'd1;
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int LONG_HOLD_AT = 750;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int SHORT_SONGS [6] = '{3, 4, 5, 6, 8, 9};

  // Tone divisors of the note table
  localparam logic [15:0] DIV_B5  = 16'(32395 / 2);
  localparam logic [15:0] DIV_D6  = 16'(54483 / 4);
  localparam logic [15:0] DIV_E6  = 16'(48539 / 4);
  localparam logic [15:0] DIV_FS6 = 16'(43243 / 4);
  localparam logic [15:0] DIV_G6  = 16'(40816 / 4);
  localparam logic [15:0] DIV_A6  = 16'(36363 / 4);
  localparam logic [15:0] DIV_D7  = 16'(54483 / 8);

  typedef struct packed {
    logic [15:0] div;
    logic [15:0] on_t;
    logic [15:0] off_t;
  } tone_note_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] divisor;
    logic        timer_run;
    logic        busy;
  } tone_result_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] melody;
    logic       drain;
  } stim_beat_t;

  localparam tone_note_t REST = '0;
  localparam tone_note_t A6_SHORT = '{DIV_A6, 16'd7, 16'd29};

  localparam tone_note_t SONG_TABLE [SONG_COUNT][NOTE_SLOTS] = '{
    '{REST, REST, REST, REST, REST, REST},
    '{'{DIV_B5, 16'd4, 16'd19}, '{DIV_D6, 16'd4, 16'd19}, '{DIV_G6, 16'd4, 16'd19},
      '{DIV_FS6, 16'd5, 16'd65}, '{DIV_D7, 16'd10, 16'd112}, REST},
    '{'{DIV_A6, 16'd4, 16'd19}, '{DIV_G6, 16'd4, 16'd19}, '{DIV_E6, 16'd4, 16'd19},
      '{DIV_FS6, 16'd5, 16'd65}, '{DIV_D6, 16'd10, 16'd110}, REST},
    '{'{DIV_A6, 16'd8, 16'd28}, REST, REST, REST, REST, REST},
    '{'{DIV_G6, 16'd5, 16'd19}, '{DIV_D7, 16'd10, 16'd38}, REST, REST, REST, REST},
    '{'{DIV_D7, 16'd5, 16'd19}, '{DIV_G6, 16'd10, 16'd38}, '{DIV_D6, 16'd0, 16'd0},
      REST, REST, REST},
    '{'{DIV_D6, 16'd2, 16'd10}, '{DIV_D7, 16'd8, 16'd28}, '{DIV_D6, 16'd2, 16'd10},
      '{DIV_D7, 16'd8, 16'd28}, REST, REST},
    '{'{DIV_B5, 16'd6, 16'd18}, '{DIV_FS6, 16'd6, 16'd18}, '{DIV_E6, 16'd6, 16'd42},
      REST, REST, REST},
    '{A6_SHORT, REST, REST, REST, REST, REST},
    '{A6_SHORT, A6_SHORT, REST, REST, REST, REST},
    '{A6_SHORT, A6_SHORT, A6_SHORT, REST, REST, REST},
    '{A6_SHORT, A6_SHORT, A6_SHORT, A6_SHORT, REST, REST},
    '{A6_SHORT, A6_SHORT, A6_SHORT, A6_SHORT, A6_SHORT, REST}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_sound_enable = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_UNUSED;
  logic [3:0]  in_melody = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tone_on;
  logic [15:0] out_note_divisor;
  logic        out_tone_timer_run;
  logic        out_busy_res;

  stim_beat_t   pending_beats [$];
  tone_result_t tone_expect [$];

  logic in_beat_taken = 1'b0;
  logic out_beat_taken = 1'b0;
  int   send_gap = 0;
  int   sent_count = 0;
  int   recv_wait = 0;
  int   results_done = 0;
  int   fail_count = 0;

  // Sequencer model state
  logic        sound_on = 1'b1;
  logic [3:0]  cur_song = '0;
  logic [3:0]  step_no = '0;
  logic [15:0] ticks_rem = '0;
  logic        power_on_done = 1'b0;
  logic        buzz = 1'b0;
  logic        timer_on = 1'b0;
  logic [15:0] div_now = '0;

  melody_tone_sequencer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_sound_enable   (cfg_sound_enable),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_melody          (in_melody),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tone_on        (out_tone_on),
    .out_note_divisor   (out_note_divisor),
    .out_tone_timer_run (out_tone_timer_run),
    .out_busy_res       (out_busy_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop playback and clear the sequence
  task automatic halt_melody();
    if (cur_song == POWER_ON_SONG) power_on_done = 1'b1;
    timer_on  = 1'b0;
    div_now   = '0;
    buzz      = 1'b0;
    ticks_rem = '0;
    step_no   = '0;
    cur_song  = '0;
  endtask

  // Apply one input beat to the model and return the outputs after it
  task automatic predict_tones(input action_t act, input logic [3:0] mel,
                               output tone_result_t res);
    tone_note_t nt;
    int ni;
    case (act)
      ACT_START: begin
        ticks_rem = '0;
        step_no   = 4'd1;
        cur_song  = mel;
      end
      ACT_TICK: begin
        if (ticks_rem != 0) ticks_rem = ticks_rem - 16'd1;
      end
      ACT_CONTROL: begin
        if (!sound_on && power_on_done) begin
          halt_melody();
        end else if (int'(cur_song) < SONG_COUNT) begin
          if (step_no == 0 && ticks_rem == 0) begin
            halt_melody();
          end else begin
            // Walk steps while no time is left; odd steps sound, even steps rest
            while (step_no >= 4'd1 && step_no <= FINAL_STEP && ticks_rem == 0) begin
              ni = (int'(step_no) - 1) / 2;
              nt = SONG_TABLE[int'(cur_song)][ni];
              if (step_no[0]) begin
                if (nt.div == 0) begin
                  halt_melody();
                end else begin
                  timer_on  = 1'b1;
                  div_now   = nt.div;
                  buzz      = 1'b1;
                  ticks_rem = nt.on_t;
                  step_no   = step_no + 4'd1;
                end
              end else begin
                buzz      = 1'b0;
                ticks_rem = nt.off_t;
                step_no   = step_no + 4'd1;
              end
            end
            if (step_no == FINAL_STEP + 4'd1 && ticks_rem == 0) halt_melody();
          end
        end
      end
      default: ;
    endcase
    res.tone_on   = buzz;
    res.divisor   = div_now;
    res.timer_run = timer_on;
    res.busy      = (step_no != 0);
  endtask

  // Observe handshakes, predict accepted beats and check result beats
  always @(posedge clk) begin : observe
    tone_result_t want;
    tone_result_t got;
    in_beat_taken  <= rst_n && in_valid && in_ready;
    out_beat_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sound_on = cfg_sound_enable;
      if (out_valid && out_ready) begin
        results_done <= results_done + 1;
        got = '{out_tone_on, out_note_divisor, out_tone_timer_run, out_busy_res};
        if (tone_expect.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          want = tone_expect.pop_front();
          if (got.tone_on !== want.tone_on) begin
            $error("tone_on expected %0d got %0d", want.tone_on, got.tone_on);
            fail_count++;
          end
          if (got.divisor !== want.divisor) begin
            $error("note_divisor expected %0d got %0d", want.divisor, got.divisor);
            fail_count++;
          end
          if (got.timer_run !== want.timer_run) begin
            $error("tone_timer_run expected %0d got %0d", want.timer_run, got.timer_run);
            fail_count++;
          end
          if (got.busy !== want.busy) begin
            $error("busy_res expected %0d got %0d", want.busy, got.busy);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_tones(action_t'(in_action), in_melody, want);
        tone_expect.push_back(want);
      end
    end
  end

  // Drive input beats from the pending queue with a random gap before each
  always @(negedge clk) begin : drive_in
    stim_beat_t nb;
    if (rst_n && (!in_valid || in_beat_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_beats.size() > 0 &&
                   !(pending_beats[0].drain && tone_expect.size() > 0)) begin
        nb = pending_beats.pop_front();
        in_valid   <= 1'b1;
        in_action  <= nb.action;
        in_melody  <= nb.melody;
        sent_count <= sent_count + 1;
        send_gap   <= (((sent_count / 40) % 3) == 0) ? 0 : $urandom_range(0, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel a random number of cycles per beat, once for long
  always @(negedge clk) begin : drive_out
    int w;
    if (rst_n) begin
      if (out_beat_taken) begin
        w = (((results_done / 50) % 3) == 1) ? 0 : $urandom_range(0, 14);
        if (results_done == LONG_HOLD_AT) w = LONG_HOLD_CYCLES;
        if (w == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          recv_wait <= w - 1;
        end
      end else if (!out_ready) begin
        if (recv_wait > 0) recv_wait <= recv_wait - 1;
        else out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_beat(input action_t a, input logic [3:0] m, input logic drain = 1'b0);
    stim_beat_t b;
    b.action = a;
    b.melody = m;
    b.drain  = drain;
    pending_beats.push_back(b);
  endtask

  // Hold until no beat is pending or in flight
  task automatic wait_idle();
    while (!(pending_beats.size() == 0 && !in_valid && tone_expect.size() == 0))
      @(posedge clk);
  endtask

  task automatic write_sound_enable(input logic v);
    wait_idle();
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_sound_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed playback: start, then ticks with a control beat after each run
  task automatic queue_random(input int target, input logic drain_first);
    int added;
    int r;
    int ticks;
    logic [3:0] m;
    added = 0;
    while (added < target) begin
      r = $urandom_range(0, 9);
      if (r <= 6) begin
        if ($urandom_range(0, 9) < 7) m = 4'(SHORT_SONGS[$urandom_range(0, 5)]);
        else m = 4'($urandom_range(0, 15));
        queue_beat(ACT_START, m, (added == 0 && drain_first) || ($urandom_range(0, 9) == 0));
        queue_beat(ACT_CONTROL, 4'($urandom_range(0, 15)));
        added += 2;
        repeat ($urandom_range(2, 14)) begin
          ticks = $urandom_range(1, 10);
          repeat (ticks) queue_beat(ACT_TICK, 4'($urandom_range(0, 15)));
          queue_beat(ACT_CONTROL, 4'($urandom_range(0, 15)));
          added += ticks + 1;
          if ($urandom_range(0, 14) == 0) begin
            queue_beat(ACT_UNUSED, 4'($urandom_range(0, 15)));
            added++;
          end
        end
      end else if (r <= 8) begin
        repeat (4) queue_beat(action_t'(2'($urandom_range(0, 3))), 4'($urandom_range(0, 15)));
        added += 4;
      end else begin
        // Restart in the middle of a melody
        queue_beat(ACT_START, 4'($urandom_range(1, 12)));
        queue_beat(ACT_CONTROL, 4'($urandom_range(0, 15)));
        queue_beat(ACT_START, 4'($urandom_range(0, 15)));
        queue_beat(ACT_CONTROL, 4'($urandom_range(0, 15)));
        added += 4;
      end
    end
  endtask

  initial begin : watchdog
    int n;
    for (n = 0; n < WATCHDOG_CYCLES; n++) @(posedge clk);
    $display("melody_tone_sequencer_core: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_sound_enable(1'b1);

    // Directed: idle control, idle tick, unused action, melody none, unknown melodies
    queue_beat(ACT_CONTROL, 4'd0);
    queue_beat(ACT_TICK, 4'd15);
    queue_beat(ACT_UNUSED, 4'd15);
    queue_beat(ACT_START, 4'd0);
    queue_beat(ACT_CONTROL, 4'd0);
    queue_beat(ACT_START, 4'd15);
    queue_beat(ACT_CONTROL, 4'd15);
    queue_beat(ACT_TICK, 4'd0);
    queue_beat(ACT_START, 4'd13);
    queue_beat(ACT_CONTROL, 4'd13);
    // Play a note, count it out, rest, then control with time left
    queue_beat(ACT_START, 4'd5);
    queue_beat(ACT_CONTROL, 4'd5);
    repeat (5) queue_beat(ACT_TICK, 4'd5);
    queue_beat(ACT_CONTROL, 4'd10);
    queue_beat(ACT_UNUSED, 4'd5);
    queue_beat(ACT_CONTROL, 4'd5);
    // Restart mid melody, then one of the longest table rows
    queue_beat(ACT_START, 4'd3);
    queue_beat(ACT_CONTROL, 4'd3);
    queue_beat(ACT_START, 4'd12);
    queue_beat(ACT_CONTROL, 4'd12);

    // Sound off: the power-on melody still plays to its end, then controls mute
    write_sound_enable(1'b0);
    queue_beat(ACT_START, POWER_ON_SONG, 1'b1);
    queue_beat(ACT_CONTROL, 4'($urandom_range(0, 15)));
    repeat (60) begin
      repeat (5) queue_beat(ACT_TICK, 4'($urandom_range(0, 15)));
      queue_beat(ACT_CONTROL, 4'($urandom_range(0, 15)));
    end
    queue_random(150, 1'b0);

    write_sound_enable(1'b1);
    queue_random(450, 1'b1);

    write_sound_enable(1'b0);
    queue_random(150, 1'b0);

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("melody_tone_sequencer_core: match");
    end else begin
      $display("melody_tone_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/mts_pkg.sv
sv/mts_ctrl.sv
sv/mts_datapath.sv
sv/melody_tone_sequencer_core.sv
sv/mts_checker.sv
test/tb_top.sv
